/* rtl/core/aelb_pkg.sv */
// Package for the angle error table builder: sizes, codes and the
// request/response types of the shared divider. No dependencies.
`timescale 1ns / 1ps

package aelb_pkg;

    // Table geometry
    localparam int LUT_ENTRIES = 64;
    localparam int INDEX_SHIFT = 10;
    localparam int IDX_W       = $clog2(LUT_ENTRIES);
    localparam int ANGLE_W     = 16;
    localparam int ACC_W       = 32;
    localparam int MEAN_W      = 16;
    localparam int SUM_W       = MEAN_W + $clog2(LUT_ENTRIES);
    localparam int OUT_IDX_W   = 6;

    // Divider operand widths
    localparam int DVD_W = ACC_W;
    localparam int DVS_W = 16;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIVISOR = CFG_IDX_W'(1);
    localparam logic [15:0]          DIVISOR_RESET      = 16'd1280;

    // Item operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic             neg;
        logic [DVD_W-1:0] magnitude;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/core/aelb_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module aelb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/aelb_div.sv */
// Restoring divider, one quotient bit per cycle, sign applied at the end.
// Depends on aelb_pkg for operand widths and the request/response types.
`timescale 1ns / 1ps

module aelb_div import aelb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dq;
    logic [DVS_W-1:0] r_div;
    logic             r_neg;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_fits;
    logic [MEAN_W-1:0] w_q;

    // One trial subtraction: the remainder stays below the divisor.
    always_comb begin
        w_trial = {r_rem, r_dq[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fits  = ~w_diff[DVS_W];
    end

    // Control and datapath of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_W'(DVD_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dq  <= i_req.magnitude;
            r_div <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_dq  <= {r_dq[DVD_W-2:0], w_fits};
        end
    end

    // Low bits of the signed quotient, truncated toward zero.
    assign w_q = r_dq[MEAN_W-1:0];
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~w_q + MEAN_W'(1)) : w_q;

endmodule

/* rtl/core/angle_error_lut_builder_core.sv */
// Top level of the angle error table builder.
// Depends on aelb_pkg, aelb_ram (accumulator and mean tables) and aelb_div.
`timescale 1ns / 1ps

// A sample item reads its bin from the accumulator RAM and then writes
// the saturated sum back, so busy is high for one cycle after each
// sample. A finish item walks the 64 bins through the shared bit-serial
// divider, each bin taking a read, a start and the division, then forms
// the table mean by a shift that rounds toward zero, then streams the 64
// entries on consecutive cycles with o_strobe high, each entry read from
// the mean RAM and registered before it is shown. The receiver cannot
// stall the stream. Accumulators read as zero after reset and after each
// finish through per-bin valid flags, so no clearing pass is needed.
// Configuration writes are always ready.

module angle_error_lut_builder_core import aelb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_op,
    input  logic [ANGLE_W-1:0]   i_commanded_angle,
    input  logic [ANGLE_W-1:0]   i_measured_angle,
    // Result channel
    output logic                 o_strobe,
    output logic [OUT_IDX_W-1:0] o_entry_index,
    output logic signed [15:0]   o_correction,
    output logic                 o_last,
    // Configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAMP,
        S_DRD,
        S_DSTART,
        S_DDIV,
        S_MSTART,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [15:0] r_angle_offset;
    logic [15:0] r_sample_divisor;

    // Control and datapath registers
    logic [IDX_W-1:0]       r_idx;
    logic [ANGLE_W-1:0]     r_err;
    logic [LUT_ENTRIES-1:0] r_acc_vld;
    logic [SUM_W-1:0]       r_sum;
    logic [MEAN_W-1:0]      r_dc;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_last;
    logic                   r_o_strobe;
    logic [OUT_IDX_W-1:0]   r_o_idx;
    logic [MEAN_W-1:0]      r_o_corr;
    logic                   r_o_last;

    // Memory ports
    logic [IDX_W-1:0]  w_acc_raddr;
    logic              w_acc_we;
    logic [ACC_W-1:0]  w_acc_rdata;
    logic [ACC_W-1:0]  n_acc;
    logic              w_mean_we;
    logic [MEAN_W-1:0] w_mean_rdata;

    // Divider
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Sample decode
    logic              w_accept;
    logic [ANGLE_W-1:0] w_err;
    logic [ANGLE_W-1:0] w_bin_full;
    logic              w_in_table;
    logic [ACC_W-1:0]  w_acc_cur;
    logic [ACC_W:0]    w_acc_sum;
    logic [DVS_W-1:0]  w_div_eff;
    logic              w_last_idx;

    // Table mean
    logic [SUM_W-1:0]  w_sum_adj;
    logic [MEAN_W-1:0] w_dc;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Wrapped angle error and bin selection of a sample.
    always_comb begin
        w_err      = i_measured_angle + r_angle_offset - i_commanded_angle;
        w_bin_full = i_commanded_angle >> INDEX_SHIFT;
        w_in_table = (w_bin_full < ANGLE_W'(LUT_ENTRIES));
        w_last_idx = (r_idx == IDX_W'(LUT_ENTRIES - 1));
    end

    // Read-modify-write of one accumulator with saturation.
    always_comb begin
        w_acc_cur = r_acc_vld[r_idx] ? w_acc_rdata : '0;
        w_acc_sum = {w_acc_cur[ACC_W-1], w_acc_cur}
                  + {{(ACC_W + 1 - ANGLE_W){r_err[ANGLE_W-1]}}, r_err};
        if (w_acc_sum[ACC_W] != w_acc_sum[ACC_W-1]) begin
            n_acc = w_acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                     : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            n_acc = w_acc_sum[ACC_W-1:0];
        end
        w_acc_raddr = (r_state == S_IDLE) ? w_bin_full[IDX_W-1:0] : r_idx;
        w_acc_we    = (r_state == S_SAMP);
        w_mean_we   = (r_state == S_DDIV) && w_div_rsp.done;
    end

    // Table mean: the table sum over the entry count, truncated toward zero.
    // A negative sum is biased by one less than the count before the shift.
    always_comb begin
        w_sum_adj = r_sum + (r_sum[SUM_W-1] ? SUM_W'(LUT_ENTRIES - 1) : SUM_W'(0));
        w_dc      = w_sum_adj[IDX_W +: MEAN_W];
    end

    // Divider requests: one per bin.
    always_comb begin
        w_div_eff = (r_sample_divisor == '0) ? DVS_W'(1) : r_sample_divisor;
        w_div_req = '0;
        unique case (r_state)
            S_DSTART: begin
                w_div_req.start     = 1'b1;
                w_div_req.neg       = w_acc_cur[ACC_W-1];
                w_div_req.magnitude = w_acc_cur[ACC_W-1] ? (~w_acc_cur + DVD_W'(1))
                                                         : w_acc_cur;
                w_div_req.divisor   = w_div_eff;
            end
            default: begin
                w_div_req = '0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_offset   <= '0;
            r_sample_divisor <= DIVISOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ANGLE_OFFSET:   r_angle_offset   <= i_cfg_data;
                CFG_SAMPLE_DIVISOR: r_sample_divisor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: state, valid flags, table sum and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc_vld  <= '0;
            r_sum      <= '0;
            r_rd_vld   <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_rd_vld   <= (r_state == S_EMIT);
            r_o_strobe <= r_rd_vld;
            // Output payload: bin mean less table mean, wrapped to 16 bits.
            if (r_rd_vld) begin
                r_o_idx  <= OUT_IDX_W'(r_rd_idx);
                r_o_corr <= w_mean_rdata - r_dc;
                r_o_last <= r_rd_last;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_op == OP_FINISH) begin
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_state <= S_DRD;
                        end else if (w_in_table) begin
                            r_idx   <= w_bin_full[IDX_W-1:0];
                            r_err   <= w_err;
                            r_state <= S_SAMP;
                        end
                    end
                end
                S_SAMP: begin
                    r_acc_vld[r_idx] <= 1'b1;
                    r_state          <= S_IDLE;
                end
                S_DRD: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DDIV;
                end
                S_DDIV: begin
                    if (w_div_rsp.done) begin
                        r_sum <= r_sum + {{(SUM_W - MEAN_W){w_div_rsp.quotient[MEAN_W-1]}},
                                          w_div_rsp.quotient};
                        if (w_last_idx) begin
                            r_state <= S_MSTART;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_DRD;
                        end
                    end
                end
                S_MSTART: begin
                    r_dc      <= w_dc;
                    r_acc_vld <= '0;
                    r_idx     <= '0;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    r_rd_idx  <= r_idx;
                    r_rd_last <= w_last_idx;
                    if (w_last_idx) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_FLUSH: begin
                    if (!r_rd_vld) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe      = r_o_strobe;
    assign o_entry_index = r_o_idx;
    assign o_correction  = r_o_corr;
    assign o_last        = r_o_last;

    // Bin accumulators.
    aelb_ram #(
        .WIDTH (ACC_W),
        .DEPTH (LUT_ENTRIES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (r_idx),
        .i_wdata (n_acc),
        .i_raddr (w_acc_raddr),
        .o_rdata (w_acc_rdata)
    );

    // Bin means of the last finish.
    aelb_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (LUT_ENTRIES)
    ) u_mean_ram (
        .i_clk   (i_clk),
        .i_we    (w_mean_we),
        .i_waddr (r_idx),
        .i_wdata (w_div_rsp.quotient),
        .i_raddr (r_idx),
        .o_rdata (w_mean_rdata)
    );

    // Shared divider for the bin means.
    aelb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

/* sim/angle_error_lut_builder_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for angle_error_lut_builder_core.
// Depends on aelb_pkg and the core; predicts every table entry and checks it.

module angle_error_lut_builder_core_tb;
    import aelb_pkg::*;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 140;
    localparam int QUIET_FROM    = 115;

    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_FINISH, ROW_FINISH_FLAT} t_row_kind;

    // One directed step: a register write (a = index, b = data), a sample
    // (a = commanded, b = measured), or a finish whose table is flat at b.
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] a;
        logic [15:0] b;
    } t_row;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic signed [15:0]   correction;
        logic                 last;
    } t_entry;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_op;
    logic [ANGLE_W-1:0]   i_commanded_angle;
    logic [ANGLE_W-1:0]   i_measured_angle;
    logic                 o_strobe;
    logic [OUT_IDX_W-1:0] o_entry_index;
    logic signed [15:0]   o_correction;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    // Predicted block state and register copies.
    int                 bin_sums [LUT_ENTRIES];
    logic signed [15:0] shadow_offset  = 16'sd0;
    logic [15:0]        shadow_divisor = DIVISOR_RESET;

    t_entry pending_entries [$];
    t_row   directed_rows [$];

    bit quiet;
    int items_sent;
    int finishes_sent;
    int cfg_writes;
    int entries_checked;
    int mismatch_count;

    angle_error_lut_builder_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_commanded_angle (i_commanded_angle),
        .i_measured_angle  (i_measured_angle),
        .o_strobe          (o_strobe),
        .o_entry_index     (o_entry_index),
        .o_correction      (o_correction),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Free-running clock, 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4000000;
        $display("angle_error_lut_builder_core: mismatch");
        $finish;
    end

    // Update the bin sums for a sample, or build the expected table for a finish.
    task automatic predict_table_step(input logic op, input logic [15:0] cmd,
                                      input logic [15:0] meas);
        logic [15:0]        raw;
        logic signed [15:0] err;
        logic signed [15:0] dc;
        logic signed [15:0] bin_means [LUT_ENTRIES];
        longint             sum;
        longint             total;
        longint             divisor;
        longint             q;
        int                 bin;
        t_entry             e;
        if (op == OP_SAMPLE) begin
            raw = meas + shadow_offset - cmd;
            err = raw;
            bin = int'(cmd >> INDEX_SHIFT);
            if (bin < LUT_ENTRIES) begin
                sum = longint'(bin_sums[bin]) + longint'(err);
                if (sum > ACC_MAX) sum = ACC_MAX;
                if (sum < ACC_MIN) sum = ACC_MIN;
                bin_sums[bin] = int'(sum);
            end
        end else begin
            // A zero divisor behaves as one.
            divisor = (shadow_divisor == 16'd0) ? 64'sd1 : longint'(shadow_divisor);
            total = 0;
            for (int i = 0; i < LUT_ENTRIES; i++) begin
                q = longint'(bin_sums[i]) / divisor;
                bin_means[i] = q[15:0];
                total += longint'(bin_means[i]);
                bin_sums[i] = 0;
            end
            q = total / LUT_ENTRIES;
            dc = q[15:0];
            for (int i = 0; i < LUT_ENTRIES; i++) begin
                e.index      = OUT_IDX_W'(i);
                e.correction = bin_means[i] - dc;
                e.last       = (i == LUT_ENTRIES - 1);
                pending_entries.push_back(e);
            end
        end
    endtask

    // Present one item, hold it until the block takes it, then maybe idle.
    task automatic send_item(input logic op, input logic [15:0] cmd, input logic [15:0] meas);
        int gap;
        @(negedge i_clk);
        start             = 1'b1;
        i_op              = op;
        i_commanded_angle = cmd;
        i_measured_angle  = meas;
        do @(posedge i_clk); while (busy);
        predict_table_step(op, cmd, meas);
        items_sent++;
        if (op == OP_FINISH) finishes_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until the whole table has been emitted.
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ANGLE_OFFSET:   shadow_offset  = data;
            CFG_SAMPLE_DIVISOR: shadow_divisor = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Compare every emitted entry with the oldest prediction.
    always @(posedge i_clk) begin
        t_entry want;
        if (i_rst_n && o_strobe) begin
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected entry, expected none, actual index %0d corr %0d",
                         $time, o_entry_index, o_correction);
                mismatch_count++;
            end else begin
                want = pending_entries.pop_front();
                entries_checked++;
                if (o_entry_index !== want.index) begin
                    $display("%0t: entry_index expected %0d actual %0d",
                             $time, want.index, o_entry_index);
                    mismatch_count++;
                end
                if (o_correction !== want.correction) begin
                    $display("%0t: correction of entry %0d expected %0d actual %0d",
                             $time, want.index, $signed(want.correction), o_correction);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last of entry %0d expected %0d actual %0d",
                             $time, want.index, want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [15:0]      cmd;
        logic [15:0]      meas;
        logic [15:0]      offset_val;
        logic [15:0]      divisor_val;
        logic [IDX_W-1:0] hot_bin;
        int               phase_len;
        int               random_base;

        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_op              = OP_SAMPLE;
        i_commanded_angle = '0;
        i_measured_angle  = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_ANGLE_OFFSET;
        i_cfg_data        = '0;
        quiet             = 1'b0;

        // Directed steps. Flat finishes carry their typed correction in b.
        // Finish straight out of reset: every bin is empty.
        directed_rows.push_back('{ROW_FINISH_FLAT, 16'h0000, 16'h0000});
        // Divisor one, offset zero: errors at both ends of the range and wrap-around.
        directed_rows.push_back('{ROW_CFG, 16'(CFG_SAMPLE_DIVISOR), 16'd1});
        directed_rows.push_back('{ROW_SAMPLE, 16'h0000, 16'hFFFF});
        directed_rows.push_back('{ROW_SAMPLE, 16'hFFFF, 16'h0000});
        directed_rows.push_back('{ROW_SAMPLE, 16'h8000, 16'h0000});
        directed_rows.push_back('{ROW_SAMPLE, 16'h0400, 16'h83FF});
        // Offset extremes.
        directed_rows.push_back('{ROW_CFG, 16'(CFG_ANGLE_OFFSET), 16'h7FFF});
        directed_rows.push_back('{ROW_SAMPLE, 16'h7C00, 16'h0000});
        directed_rows.push_back('{ROW_CFG, 16'(CFG_ANGLE_OFFSET), 16'h8000});
        directed_rows.push_back('{ROW_SAMPLE, 16'h03FF, 16'hFFFF});
        directed_rows.push_back('{ROW_FINISH, 16'h0000, 16'h0000});
        // Zero divisor acts as one; writes to spare indexes must change nothing.
        directed_rows.push_back('{ROW_CFG, 16'(CFG_ANGLE_OFFSET), 16'h0000});
        directed_rows.push_back('{ROW_CFG, 16'(CFG_SAMPLE_DIVISOR), 16'h0000});
        directed_rows.push_back('{ROW_CFG, 16'(CFG_SPARE_2), 16'hFFFF});
        directed_rows.push_back('{ROW_CFG, 16'(CFG_SPARE_3), 16'h5A5A});
        directed_rows.push_back('{ROW_SAMPLE, 16'h1234, 16'h5678});
        directed_rows.push_back('{ROW_SAMPLE, 16'hAAAA, 16'h5555});
        directed_rows.push_back('{ROW_SAMPLE, 16'hAAAB, 16'h0000});
        directed_rows.push_back('{ROW_FINISH, 16'hFFFF, 16'hFFFF});
        // Largest divisor swallows small sums: the table is flat zero.
        directed_rows.push_back('{ROW_CFG, 16'(CFG_SAMPLE_DIVISOR), 16'hFFFF});
        directed_rows.push_back('{ROW_SAMPLE, 16'h0000, 16'h7FFF});
        directed_rows.push_back('{ROW_SAMPLE, 16'h0001, 16'h8000});
        directed_rows.push_back('{ROW_FINISH_FLAT, 16'h0000, 16'h0000});
        directed_rows.push_back('{ROW_CFG, 16'(CFG_SAMPLE_DIVISOR), DIVISOR_RESET});

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table.
        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CFG: begin
                    settle();
                    write_reg(directed_rows[r].a[CFG_IDX_W-1:0], directed_rows[r].b);
                end
                ROW_SAMPLE: send_item(OP_SAMPLE, directed_rows[r].a, directed_rows[r].b);
                ROW_FINISH: send_item(OP_FINISH, directed_rows[r].a, directed_rows[r].b);
                ROW_FINISH_FLAT: begin
                    send_item(OP_FINISH, directed_rows[r].a, directed_rows[r].b);
                    for (int k = pending_entries.size() - LUT_ENTRIES;
                         k < pending_entries.size(); k++) begin
                        pending_entries[k].correction = directed_rows[r].b;
                    end
                end
                default: ;
            endcase
        end

        // Random phases: new settings, a run of samples, then a finish.
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 3))
                0:       offset_val = 16'h8000;
                1:       offset_val = 16'h7FFF;
                2:       offset_val = 16'h0000;
                default: offset_val = 16'($urandom);
            endcase
            write_reg(CFG_ANGLE_OFFSET, offset_val);
            case ($urandom_range(0, 5))
                0:       divisor_val = 16'h0000;
                1:       divisor_val = 16'h0001;
                2:       divisor_val = 16'hFFFF;
                3:       divisor_val = 16'($urandom_range(17, 65535));
                default: divisor_val = 16'($urandom_range(1, 16));
            endcase
            write_reg(CFG_SAMPLE_DIVISOR, divisor_val);
            hot_bin   = IDX_W'($urandom_range(0, LUT_ENTRIES - 1));
            phase_len = $urandom_range(10, 40);
            repeat (phase_len) begin
                quiet = (items_sent - random_base) >= QUIET_FROM;
                if ($urandom_range(0, 99) < 4) begin
                    // An early finish in the middle of a run.
                    send_item(OP_FINISH, 16'($urandom), 16'($urandom));
                end else begin
                    cmd = 16'($urandom);
                    if ($urandom_range(0, 1) == 1) cmd[ANGLE_W-1:INDEX_SHIFT] = hot_bin;
                    // Mostly a sensor reading close to the commanded angle less the offset.
                    if ($urandom_range(0, 9) < 7)
                        meas = cmd - shadow_offset + 16'($urandom_range(0, 2047)) - 16'd1024;
                    else
                        meas = 16'($urandom);
                    send_item(OP_SAMPLE, cmd, meas);
                end
            end
            quiet = (items_sent - random_base) >= QUIET_FROM;
            send_item(OP_FINISH, 16'($urandom), 16'($urandom));
        end

        // Drain the last table and give the block time to go quiet.
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items with %0d finishes, %0d register writes, %0d entries checked.",
                 items_sent, finishes_sent, cfg_writes, entries_checked);
        $display("Offsets and divisors covered their extremes, a zero divisor and spare indexes.");
        if (mismatch_count == 0) begin
            $display("angle_error_lut_builder_core: match");
        end else begin
            $display("angle_error_lut_builder_core: mismatch");
        end
        $finish;
    end

endmodule
